[hdl/sida_pkg.sv]
// shared types and constants for the signed integer to decimal text unit
package sida_pkg;

   localparam int VALUE_BITS          = 64;
   localparam int DEFAULT_VALUE_WIDTH = 64;
   localparam int CHAR_W              = 8;
   localparam int DIGIT_W             = 4;
   localparam int BITS_PER_STEP       = 4;

   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
   localparam logic [DIGIT_W-1:0] BCD_ADJUST_MIN = 4'd5;
   localparam logic [DIGIT_W-1:0] BCD_ADJUST     = 4'd3;
   localparam logic [DIGIT_W-1:0] BCD_MAX        = 4'd9;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_FIND,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic find;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   typedef struct packed {
      logic last_step;
      logic negative;
      logic last_digit;
      logic out_free;
   } status_type;

endpackage

[hdl/sida_req_if.sv]
// request channel carrying one signed integer
interface sida_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [sida_pkg::VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

[hdl/sida_rsp_if.sv]
// response channel carrying one ascii character
interface sida_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [sida_pkg::CHAR_W-1:0]      ascii_char;
   logic                             last_char;

   modport source (output valid, output ascii_char, output last_char, input ready);
   modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

[hdl/sida_controller.sv]
// sequencing state machine for the conversion
module sida_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sida_pkg::status_type status,
   output sida_pkg::cmd_type    cmd
);

   sida_pkg::state_type state_ff;
   sida_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sida_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sida_pkg::ST_IDLE: begin
            if (req_valid) state_in = sida_pkg::ST_CONVERT;
         end
         sida_pkg::ST_CONVERT: begin
            if (status.last_step) state_in = sida_pkg::ST_FIND;
         end
         sida_pkg::ST_FIND: begin
            state_in = status.negative ? sida_pkg::ST_SIGN : sida_pkg::ST_DIGITS;
         end
         sida_pkg::ST_SIGN: begin
            if (status.out_free) state_in = sida_pkg::ST_DIGITS;
         end
         sida_pkg::ST_DIGITS: begin
            if (status.out_free && status.last_digit) state_in = sida_pkg::ST_IDLE;
         end
         default: state_in = sida_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         sida_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         sida_pkg::ST_CONVERT: cmd.shift      = 1'b1;
         sida_pkg::ST_FIND:    cmd.find       = 1'b1;
         sida_pkg::ST_SIGN:    cmd.emit_sign  = status.out_free;
         sida_pkg::ST_DIGITS:  cmd.emit_digit = status.out_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

[hdl/sida_datapath.sv]
// magnitude, bcd shift register and output character register
module sida_datapath #(
   parameter int VALUE_WIDTH = sida_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   sida_req_if.sink             req_ch,
   sida_rsp_if.source           rsp_ch,
   input  sida_pkg::cmd_type    cmd,
   output sida_pkg::status_type status
);

   localparam int STEPS  = (VALUE_WIDTH + sida_pkg::BITS_PER_STEP - 1) / sida_pkg::BITS_PER_STEP;
   localparam int MAG_W  = STEPS * sida_pkg::BITS_PER_STEP;
   localparam int NDIG   = (VALUE_WIDTH * 78) / 256 + 1;
   localparam int BCD_W  = NDIG * sida_pkg::DIGIT_W;
   localparam int IDX_W  = $clog2(NDIG);
   localparam int STEP_W = $clog2(STEPS);

   logic [MAG_W-1:0]  mag_ff,  mag_in;
   logic [BCD_W-1:0]  bcd_ff,  bcd_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0]  idx_ff,  idx_in;
   logic              neg_ff,  neg_in;
   logic              out_valid_ff, out_valid_in;
   logic [sida_pkg::CHAR_W-1:0] out_char_ff, out_char_in;
   logic              out_last_ff, out_last_in;

   logic [VALUE_WIDTH-1:0]     value_low;
   logic [VALUE_WIDTH-1:0]     value_abs;
   logic [BCD_W-1:0]           bcd_work;
   logic [MAG_W-1:0]           mag_work;
   logic [IDX_W-1:0]           lead_idx;
   logic [sida_pkg::DIGIT_W-1:0] cur_digit;
   logic                       out_free;

   assign value_low = req_ch.value[VALUE_WIDTH-1:0];
   assign value_abs = value_low[VALUE_WIDTH-1] ? (~value_low + 1'b1) : value_low;
   assign cur_digit = bcd_ff[idx_ff * sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W];
   assign out_free  = !out_valid_ff || rsp_ch.ready;

   // double dabble, four bits per cycle
   always_comb begin
      bcd_work = bcd_ff;
      mag_work = mag_ff;
      for (int s = 0; s < sida_pkg::BITS_PER_STEP; s++) begin
         for (int d = 0; d < NDIG; d++) begin
            if (bcd_work[d*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] >= sida_pkg::BCD_ADJUST_MIN)
               bcd_work[d*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] =
                  bcd_work[d*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] + sida_pkg::BCD_ADJUST;
         end
         {bcd_work, mag_work} = {bcd_work, mag_work} << 1;
      end
   end

   // most significant nonzero digit, zero value falls back to digit 0
   always_comb begin
      lead_idx = '0;
      for (int d = 0; d < NDIG; d++) begin
         if (bcd_ff[d*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] != '0) lead_idx = IDX_W'(d);
      end
   end

   always_comb begin
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      neg_in       = neg_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      if (cmd.load) begin
         mag_in  = MAG_W'(value_abs);
         bcd_in  = '0;
         step_in = '0;
         neg_in  = value_low[VALUE_WIDTH-1];
      end
      if (cmd.shift) begin
         mag_in  = mag_work;
         bcd_in  = bcd_work;
         step_in = step_ff + 1'b1;
      end
      if (cmd.find) idx_in = lead_idx;
      if (cmd.emit_sign) begin
         out_char_in  = sida_pkg::CHAR_MINUS;
         out_last_in  = 1'b0;
         out_valid_in = 1'b1;
      end
      if (cmd.emit_digit) begin
         out_char_in  = sida_pkg::CHAR_ZERO + sida_pkg::CHAR_W'(cur_digit);
         out_last_in  = (idx_ff == '0);
         out_valid_in = 1'b1;
         idx_in       = idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      step_ff     <= step_in;
      idx_ff      <= idx_in;
      neg_ff      <= neg_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign status.last_step  = (step_ff == STEP_W'(STEPS - 1));
   assign status.negative   = neg_ff;
   assign status.last_digit = (idx_ff == '0);
   assign status.out_free   = out_free;

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.ascii_char = out_char_ff;
   assign rsp_ch.last_char  = out_last_ff;

   // a new character never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_sign || cmd.emit_digit) |-> (!out_valid_ff || rsp_ch.ready))
      else $error("character register overwritten");

   // every emitted digit is a valid bcd digit
   a_bcd_digit: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_digit |-> (cur_digit <= sida_pkg::BCD_MAX))
      else $error("bcd digit out of range");

   // leading digit search lands on a nonzero digit unless the value is zero
   a_lead_digit: assert property (@(posedge clock) disable iff (reset)
      cmd.find |=> (idx_ff == '0 || cur_digit != '0))
      else $error("leading digit points at zero");

   // conversion never starts mid-emission
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !(cmd.shift || cmd.emit_digit || cmd.emit_sign))
      else $error("load overlaps other work");

endmodule

[hdl/signed_integer_to_decimal_ascii_unit.sv]
// top level of the signed integer to decimal ascii text unit
//
// req_ch carries one signed integer per request; only the low VALUE_WIDTH
// bits are used, read as two's complement. rsp_ch returns the decimal
// text one ascii character per response, most significant first: a
// leading '-' for negative values, no leading zeros, '0' for zero, and
// last_char set on the final digit.
//
// sequence: take the request, then binary to bcd conversion with four
// shift-and-adjust steps per cycle, then locate the leading digit, then
// one character per cycle while the receiver takes them. at width 64 a
// request yields up to 20 characters. a new request is taken only after
// the final character of the previous one has been emitted.
//
// a response register sits on the output, so the next request is taken
// while the final character still waits. when rsp_ch.ready is low the
// current character holds and emission pauses. synchronous reset empties
// the response register and returns the controller to idle.
module signed_integer_to_decimal_ascii_unit #(
   parameter int VALUE_WIDTH = sida_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   sida_req_if.sink    req_ch,
   sida_rsp_if.source  rsp_ch
);

   // command and status between sequencer and datapath
   sida_pkg::cmd_type    cmd;
   sida_pkg::status_type status;

   // sequencer: idle, convert, find leading digit, sign, digits
   sida_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // magnitude, bcd digits and the response register
   sida_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cmd    (cmd),
      .status (status)
   );

endmodule

[tb/sida_text_checker.sv]
// checker for the decimal text unit: predicts characters per request and compares responses
`timescale 1ns / 1ps

module sida_text_checker #(
   parameter int VALUE_WIDTH = sida_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic  clock,
   input  logic  reset,
   sida_req_if   req_ch,
   sida_rsp_if   rsp_ch,
   output int    fail_count,
   output int    chars_pending
);

   localparam int MAX_DIGITS = 19;

   typedef struct packed {
      logic [sida_pkg::CHAR_W-1:0] ascii_char;
      logic                        last_char;
   } text_char_type;

   text_char_type expected_text[$];

   // decimal text of the low VALUE_WIDTH bits, read as two's complement
   task automatic predict_text(input logic [sida_pkg::VALUE_BITS-1:0] raw);
      logic [sida_pkg::VALUE_BITS-1:0] width_mask;
      logic [sida_pkg::VALUE_BITS-1:0] sign_bit;
      logic [sida_pkg::VALUE_BITS-1:0] bits;
      logic [sida_pkg::VALUE_BITS-1:0] magnitude;
      logic [sida_pkg::VALUE_BITS-1:0] remainder;
      logic [sida_pkg::DIGIT_W-1:0]    digits[MAX_DIGITS];
      logic                            negative;
      text_char_type                   next_char;
      int                              ndig;
      int                              k;
      width_mask = {sida_pkg::VALUE_BITS{1'b1}} >> (sida_pkg::VALUE_BITS - VALUE_WIDTH);
      sign_bit   = 64'd1 << (VALUE_WIDTH - 1);
      bits       = raw & width_mask;
      negative   = |(bits & sign_bit);
      // unsigned magnitude, so the most negative value stays exact
      magnitude  = negative ? ((64'd0 - bits) & width_mask) : bits;
      ndig = 0;
      do begin
         remainder    = magnitude % 64'd10;
         digits[ndig] = remainder[sida_pkg::DIGIT_W-1:0];
         magnitude    = magnitude / 64'd10;
         ndig++;
      end while (magnitude != 0 && ndig < MAX_DIGITS);
      if (negative) begin
         next_char.ascii_char = sida_pkg::CHAR_MINUS;
         next_char.last_char  = 1'b0;
         expected_text.push_back(next_char);
      end
      for (k = ndig - 1; k >= 0; k--) begin
         next_char.ascii_char = sida_pkg::CHAR_ZERO + {4'd0, digits[k]};
         next_char.last_char  = (k == 0);
         expected_text.push_back(next_char);
      end
   endtask

   always @(posedge clock) begin : watch
      text_char_type want;
      if (reset) begin
         expected_text.delete();
         fail_count <= 0;
      end else begin
         // compare before predicting: a response never belongs to this cycle's request
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_text.size() == 0) begin
               $display("%0t: unexpected character, expected none, got %0d last %b",
                        $time, rsp_ch.ascii_char, rsp_ch.last_char);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_text.pop_front();
               if (want.ascii_char !== rsp_ch.ascii_char ||
                   want.last_char !== rsp_ch.last_char) begin
                  $display("%0t: character mismatch, expected %0d last %b, got %0d last %b",
                           $time, want.ascii_char, want.last_char,
                           rsp_ch.ascii_char, rsp_ch.last_char);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_text(req_ch.value);
         end
      end
      chars_pending <= expected_text.size();
   end

endmodule

[tb/tb.sv]
// testbench top for the signed integer to decimal ascii unit: stimulus, stalls and verdict
`timescale 1ns / 1ps

module tb;

   localparam int VALUE_WIDTH   = sida_pkg::DEFAULT_VALUE_WIDTH;
   localparam int RANDOM_ITEMS  = 470;
   localparam int CALM_FROM     = 400;   // no idling on either side from this request on
   localparam int DRAIN_AT      = 235;   // sender waits for every character here
   localparam int LONG_HOLD     = 400;   // receiver hold-off right after reset
   localparam int STALL_LIMIT   = 4000;  // cycles without any handshake
   localparam int SETTLE_CYCLES = 60;
   localparam int NUM_CORNERS   = 20;

   // extremes, digit-count boundaries and alternating bit patterns
   localparam logic [sida_pkg::VALUE_BITS-1:0] CORNERS[NUM_CORNERS] = '{
      64'd0,
      64'd1,
      64'hFFFF_FFFF_FFFF_FFFF,            // minus one
      64'd9,
      64'd10,
      64'hFFFF_FFFF_FFFF_FFF6,            // minus ten
      64'd99,
      64'd100,
      64'h7FFF_FFFF_FFFF_FFFF,            // most positive
      64'h8000_0000_0000_0000,            // most negative, twenty characters
      64'h8000_0000_0000_0001,
      64'd999999999999999999,
      64'd1000000000000000000,
      -64'd1000000000000000000,
      64'h5555_5555_5555_5555,
      64'hAAAA_AAAA_AAAA_AAAA,
      64'd12345,
      -64'd123456789,
      -64'd9,
      64'hFFFF_FFFF_FFFF_FFFE
   };

   typedef enum int {
      PICK_RAW,
      PICK_SMALL,
      PICK_DECADE,
      PICK_DIGITS
   } pick_kind_type;

   logic clock;
   logic reset;
   bit   calm;
   int   fail_count;
   int   chars_pending;

   sida_req_if req_ch ();
   sida_rsp_if rsp_ch ();

   signed_integer_to_decimal_ascii_unit #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   sida_text_checker #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) text_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .fail_count    (fail_count),
      .chars_pending (chars_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // random integer with a spread of digit counts and signs
   function automatic logic [sida_pkg::VALUE_BITS-1:0] pick_value();
      pick_kind_type                   kind;
      logic [sida_pkg::VALUE_BITS-1:0] mag;
      int                              ndig;
      kind = pick_kind_type'($urandom_range(0, 3));
      case (kind)
         PICK_RAW: begin
            return {$urandom, $urandom};
         end
         PICK_SMALL: begin
            mag = 64'($urandom_range(0, 999));
         end
         PICK_DECADE: begin
            // powers of ten and their neighbors, where the digit count changes
            mag = 64'd1;
            repeat ($urandom_range(0, 18)) mag = mag * 64'd10;
            mag = mag + $urandom_range(0, 2) - 64'd1;
         end
         default: begin
            mag  = 64'd0;
            ndig = $urandom_range(1, 19);
            repeat (ndig) mag = mag * 64'd10 + $urandom_range(0, 9);
         end
      endcase
      if ($urandom_range(0, 1) == 1) begin
         mag = 64'd0 - mag;
      end
      return mag;
   endfunction

   // hold one request on the channel until the unit takes it
   task automatic offer_value(input logic [sida_pkg::VALUE_BITS-1:0] v);
      req_ch.valid <= 1'b1;
      req_ch.value <= v;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // sender idles for a burst of cycles
   task automatic idle_sender(input int cycles);
      req_ch.valid <= 1'b0;
      req_ch.value <= {$urandom, $urandom};
      repeat (cycles) @(posedge clock);
   endtask

   // sender idles until every predicted character has come back
   task automatic drain_text();
      req_ch.valid <= 1'b0;
      @(posedge clock);   // checker count is registered, so it lags the last handshake
      while (chars_pending != 0) @(posedge clock);
   endtask

   // request side: directed values, then random ones with idle bursts
   initial begin
      req_ch.valid <= 1'b0;
      req_ch.value <= '0;
      reset        <= 1'b1;
      calm          = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // back to back while the receiver holds off, so the unit fills and stalls input
      foreach (CORNERS[i]) begin
         offer_value(CORNERS[i]);
      end
      drain_text();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == DRAIN_AT) begin
            drain_text();
         end
         if (n == CALM_FROM) begin
            calm = 1'b1;
         end
         if (!calm && $urandom_range(0, 3) == 0) begin
            idle_sender($urandom_range(1, 18));
         end
         offer_value(pick_value());
      end
      drain_text();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0 && chars_pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // response side: one long hold-off after reset, then random stall bursts
   initial begin
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      repeat (LONG_HOLD) @(posedge clock);
      while (!calm) begin
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
      end
      rsp_ch.ready <= 1'b1;
   end

   // watchdog: any handshake on either channel restarts the count
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("%0t: no handshake for %0d cycles, %0d characters outstanding",
               $time, STALL_LIMIT, chars_pending);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

[sim.f]
hdl/sida_pkg.sv
hdl/sida_req_if.sv
hdl/sida_rsp_if.sv
hdl/sida_controller.sv
hdl/sida_datapath.sv
hdl/signed_integer_to_decimal_ascii_unit.sv
tb/sida_text_checker.sv
tb/tb.sv
